// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define AST_IMP(lbl, clk, rst_n, ante, cons)
`define AST_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/ccf_pkg.sv =====
// shared types and constants of the cosine recommender
package ccf_pkg;

    localparam logic       ACT_LOAD  = 1'b0;
    localparam logic       ACT_QUERY = 1'b1;

    localparam logic [1:0] CFG_TOP_N  = 2'd0;
    localparam logic [1:0] CFG_USERS  = 2'd1;
    localparam logic [1:0] CFG_MOVIES = 2'd2;

    localparam int SIM_W      = 17;
    localparam int PRED_W     = 16;
    localparam int OUT_MOV_W  = 5;
    localparam int RESULT_CAP = 32;
    localparam int SQ_IN_W    = 34;
    localparam int SQ_STEPS   = 17;

    // controller to datapath
    typedef struct packed {
        logic st_we;
        logic acc_clr;
        logic sim_acc;
        logic sim_mul;
        logic div_sim_start;
        logic div_pred_start;
        logic sqrt_start;
        logic cache_we;
        logic cache_zero;
        logic pred_acc;
        logic self_u;
        logic list_we;
        logic pred_zero;
        logic q_start;
        logic sel_clr;
        logic sel_acc;
        logic out_load_item;
        logic out_load_none;
        logic out_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic p_zero;
        logic ss_zero;
        logic div_done;
        logic sqrt_done;
        logic tgt_rated;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/ccf_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module ccf_div #(
    parameter int DVD_W = 76,
    parameter int DVS_W = 44
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_q
);
    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dq;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [DVS_W:0]   w_t;
    logic             w_ge;

    assign w_t  = {r_rem, r_dq[DVD_W-1]};
    assign w_ge = w_t >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dvd;
            r_dvs <= i_dvs;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? DVS_W'(w_t - {1'b0, r_dvs}) : w_t[DVS_W-1:0];
            r_dq  <= {r_dq[DVD_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_dq;
endmodule

// ===== sv/ccf_ctrl.sv =====
// query sequencer: store clearing, loads, similarity walk, prediction walk, selection
module ccf_ctrl #(
    parameter int MAX_USERS   = 64,
    parameter int MAX_MOVIES  = 32,
    parameter int RATING_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [5:0]            i_user_index,
    input  logic [4:0]            i_movie_index,
    input  logic [3:0]            i_rating,
    input  logic [5:0]            i_top_n,
    input  logic [6:0]            i_users,
    input  logic [5:0]            i_movies,
    input  ccf_pkg::t_sts         i_sts,
    output ccf_pkg::t_cmd         o_cmd,
    output logic [$clog2(MAX_USERS)-1:0]                        o_user,
    output logic [$clog2(MAX_USERS)-1:0]                        o_tgt,
    output logic [(MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1)-1:0] o_movie,
    output logic [(MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1)-1:0] o_list_raddr,
    output logic [(MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1)-1:0] o_list_waddr,
    output logic [$clog2(MAX_USERS)-1:0]                        o_st_wuser,
    output logic [(MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1)-1:0] o_st_wmovie,
    output logic [RATING_BITS-1:0]                              o_st_wdata
);
    import ccf_pkg::*;

    localparam int UB = $clog2(MAX_USERS);
    localparam int MB = MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1;
    localparam int UC = $clog2(MAX_USERS + 1);
    localparam int MC = $clog2(MAX_MOVIES + 1);

    typedef enum logic [19:0] {
        ST_CLEAR    = 20'h00001,
        ST_IDLE     = 20'h00002,
        ST_SIM_RD   = 20'h00004,
        ST_SIM_DRN  = 20'h00008,
        ST_SIM_MUL  = 20'h00010,
        ST_SIM_DST  = 20'h00020,
        ST_SIM_DIV  = 20'h00040,
        ST_SIM_SQRT = 20'h00080,
        ST_SIM_WR   = 20'h00100,
        ST_PRD_CHK  = 20'h00200,
        ST_PRD_TST  = 20'h00400,
        ST_PRD_ACC  = 20'h00800,
        ST_PRD_DRN  = 20'h01000,
        ST_PRD_DST  = 20'h02000,
        ST_PRD_DIV  = 20'h04000,
        ST_PRD_WR   = 20'h08000,
        ST_SEL_RD   = 20'h10000,
        ST_SEL_DRN  = 20'h20000,
        ST_SEL_OUT  = 20'h40000,
        ST_NONE     = 20'h80000
    } t_state;

    t_state          r_state, n_state;
    logic [UC-1:0]   r_u, n_u;
    logic [MC-1:0]   r_m, n_m;
    logic [MC-1:0]   r_j, n_j;
    logic [MC-1:0]   r_cnt, n_cnt;
    logic [6:0]      r_k, n_k;
    logic [UB-1:0]   r_tgt, n_tgt;
    logic            r_zero, n_zero;
    logic [UB+MB-1:0] r_clr, n_clr;

    logic [UC-1:0]   w_users_e;
    logic [MC-1:0]   w_movies_e;
    logic [5:0]      w_limit;
    logic [6:0]      w_lim;
    logic            w_tgt_ok;
    logic            w_ld_ok;

    assign w_users_e  = (32'(i_users) > MAX_USERS) ? UC'(MAX_USERS) : UC'(i_users);
    assign w_movies_e = (32'(i_movies) > MAX_MOVIES) ? MC'(MAX_MOVIES) : MC'(i_movies);
    assign w_limit    = (32'(i_top_n) > RESULT_CAP) ? 6'(RESULT_CAP) : i_top_n;
    assign w_lim      = (7'(w_limit) > 7'(r_cnt)) ? 7'(r_cnt) : 7'(w_limit);
    assign w_tgt_ok   = 32'(i_user_index) < MAX_USERS;
    assign w_ld_ok    = w_tgt_ok && (32'(i_movie_index) < MAX_MOVIES);

    always_comb begin
        logic [MC-1:0] cnt_now;
        logic          movie_step;
        n_state    = r_state;
        n_u        = r_u;
        n_m        = r_m;
        n_j        = r_j;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_tgt      = r_tgt;
        n_zero     = r_zero;
        n_clr      = r_clr;
        o_cmd      = '0;
        cnt_now    = r_cnt;
        movie_step = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.st_we = 1'b1;
                n_clr       = r_clr + (UB+MB)'(1);
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_LOAD) begin
                        o_cmd.st_we = w_ld_ok;
                    end else begin
                        n_tgt = UB'(i_user_index);
                        n_u   = '0;
                        n_m   = '0;
                        n_cnt = '0;
                        o_cmd.acc_clr = 1'b1;
                        o_cmd.q_start = 1'b1;
                        if (!w_tgt_ok || w_limit == 6'd0 || w_movies_e == '0) begin
                            n_state = ST_NONE;
                        end else if (w_users_e == '0) begin
                            n_state = ST_PRD_CHK;
                        end else begin
                            n_state = ST_SIM_RD;
                        end
                    end
                end
            end
            ST_SIM_RD: begin
                o_cmd.sim_acc = 1'b1;
                if (r_m + MC'(1) == w_movies_e) begin
                    n_m     = '0;
                    n_state = ST_SIM_DRN;
                end else begin
                    n_m = r_m + MC'(1);
                end
            end
            ST_SIM_DRN: n_state = ST_SIM_MUL;
            ST_SIM_MUL: begin
                o_cmd.sim_mul = 1'b1;
                n_state       = ST_SIM_DST;
            end
            ST_SIM_DST: begin
                if (i_sts.p_zero || r_u == UC'(r_tgt)) begin
                    n_zero  = 1'b1;
                    n_state = ST_SIM_WR;
                end else begin
                    n_zero              = 1'b0;
                    o_cmd.div_sim_start = 1'b1;
                    n_state             = ST_SIM_DIV;
                end
            end
            ST_SIM_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = ST_SIM_SQRT;
                end
            end
            ST_SIM_SQRT: begin
                if (i_sts.sqrt_done) begin
                    n_state = ST_SIM_WR;
                end
            end
            ST_SIM_WR: begin
                o_cmd.cache_we   = 1'b1;
                o_cmd.cache_zero = r_zero;
                o_cmd.acc_clr    = 1'b1;
                if (r_u + UC'(1) == w_users_e) begin
                    n_u     = '0;
                    n_m     = '0;
                    n_state = ST_PRD_CHK;
                end else begin
                    n_u     = r_u + UC'(1);
                    n_state = ST_SIM_RD;
                end
            end
            ST_PRD_CHK: n_state = ST_PRD_TST;
            ST_PRD_TST: begin
                if (i_sts.tgt_rated) begin
                    movie_step = 1'b1;
                end else begin
                    o_cmd.acc_clr = 1'b1;
                    n_u           = '0;
                    n_state       = (w_users_e == '0) ? ST_PRD_DST : ST_PRD_ACC;
                end
            end
            ST_PRD_ACC: begin
                o_cmd.pred_acc = 1'b1;
                o_cmd.self_u   = (r_u == UC'(r_tgt));
                if (r_u + UC'(1) == w_users_e) begin
                    n_state = ST_PRD_DRN;
                end else begin
                    n_u = r_u + UC'(1);
                end
            end
            ST_PRD_DRN: n_state = ST_PRD_DST;
            ST_PRD_DST: begin
                if (i_sts.ss_zero) begin
                    n_zero  = 1'b1;
                    n_state = ST_PRD_WR;
                end else begin
                    n_zero               = 1'b0;
                    o_cmd.div_pred_start = 1'b1;
                    n_state              = ST_PRD_DIV;
                end
            end
            ST_PRD_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_PRD_WR;
                end
            end
            ST_PRD_WR: begin
                o_cmd.list_we   = 1'b1;
                o_cmd.pred_zero = r_zero;
                cnt_now         = r_cnt + MC'(1);
                n_cnt           = cnt_now;
                movie_step      = 1'b1;
            end
            ST_SEL_RD: begin
                o_cmd.sel_acc = 1'b1;
                if (r_j + MC'(1) == r_cnt) begin
                    n_j     = '0;
                    n_state = ST_SEL_DRN;
                end else begin
                    n_j = r_j + MC'(1);
                end
            end
            ST_SEL_DRN: n_state = ST_SEL_OUT;
            ST_SEL_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_item = 1'b1;
                    o_cmd.out_last      = (r_k + 7'd1 == w_lim);
                    if (r_k + 7'd1 == w_lim) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k           = r_k + 7'd1;
                        o_cmd.sel_clr = 1'b1;
                        n_state       = ST_SEL_RD;
                    end
                end
            end
            ST_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_none = 1'b1;
                    o_cmd.out_last      = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // advance to the next movie of the prediction walk, or end it after the last movie
        if (movie_step) begin
            if (r_m + MC'(1) == w_movies_e) begin
                n_k = '0;
                n_j = '0;
                if (cnt_now == '0) begin
                    n_state = ST_NONE;
                end else begin
                    o_cmd.sel_clr = 1'b1;
                    n_state       = ST_SEL_RD;
                end
            end else begin
                n_m     = r_m + MC'(1);
                n_state = ST_PRD_CHK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_u     <= '0;
            r_m     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_tgt   <= '0;
            r_zero  <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_u     <= n_u;
            r_m     <= n_m;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_tgt   <= n_tgt;
            r_zero  <= n_zero;
            r_clr   <= n_clr;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_user       = r_u[UB-1:0];
    assign o_tgt        = r_tgt;
    assign o_movie      = r_m[MB-1:0];
    assign o_list_raddr = r_j[MB-1:0];
    assign o_list_waddr = r_cnt[MB-1:0];
    assign o_st_wuser   = (r_state == ST_CLEAR) ? r_clr[UB+MB-1:MB] : UB'(i_user_index);
    assign o_st_wmovie  = (r_state == ST_CLEAR) ? r_clr[MB-1:0] : MB'(i_movie_index);
    assign o_st_wdata   = (r_state == ST_CLEAR) ? '0 : RATING_BITS'(i_rating);
endmodule

// ===== sv/ccf_dp.sv =====
// datapath: rating store, accumulators, divider, square root, selection, output
module ccf_dp #(
    parameter int MAX_USERS   = 64,
    parameter int MAX_MOVIES  = 32,
    parameter int RATING_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ccf_pkg::t_cmd         i_cmd,
    output ccf_pkg::t_sts         o_sts,
    input  logic [$clog2(MAX_USERS)-1:0]                        i_user,
    input  logic [$clog2(MAX_USERS)-1:0]                        i_tgt,
    input  logic [(MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1)-1:0] i_movie,
    input  logic [(MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1)-1:0] i_list_raddr,
    input  logic [(MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1)-1:0] i_list_waddr,
    input  logic [$clog2(MAX_USERS)-1:0]                        i_st_wuser,
    input  logic [(MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1)-1:0] i_st_wmovie,
    input  logic [RATING_BITS-1:0]                              i_st_wdata,
    input  logic                  i_m_tready,
    output logic                  o_m_valid,
    output logic [4:0]            o_movie_id,
    output logic [15:0]           o_pred,
    output logic                  o_found,
    output logic                  o_last
);
    import ccf_pkg::*;

    localparam int RB    = RATING_BITS;
    localparam int UB    = $clog2(MAX_USERS);
    localparam int MB    = MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1;
    localparam int UC    = $clog2(MAX_USERS + 1);
    localparam int MC    = $clog2(MAX_MOVIES + 1);
    localparam int ACC_W = 2 * RB + MC;
    localparam int P_W   = 2 * ACC_W;
    localparam int SS_W  = SIM_W + UC;
    localparam int WS_W  = SIM_W + RB + UC;
    localparam int DVS_W = P_W > SS_W ? P_W : SS_W;
    localparam int DVD_W = (P_W + 32) > (WS_W + 12) ? (P_W + 32) : (WS_W + 12);
    localparam int LW    = MB + PRED_W;

    // memories
    logic [RB-1:0]    r_store [0:2**(UB+MB)-1];
    logic [SIM_W-1:0] r_cache [0:2**UB-1];
    logic [LW-1:0]    r_list  [0:2**MB-1];

    logic [RB-1:0]    r_ra, r_rb;
    logic [SIM_W-1:0] r_sim_q;
    logic [LW-1:0]    r_lq;

    logic             r_sim_v, r_pred_v, r_self_d, r_sel_v;
    logic [MB-1:0]    r_j_d;

    logic [ACC_W-1:0] r_dot, r_n1, r_n2;
    logic [P_W-1:0]   r_num, r_p;
    logic [WS_W-1:0]  r_ws;
    logic [SS_W-1:0]  r_ss;

    logic [2*RB-1:0]     w_pxy, w_pxx, w_pyy;
    logic [SIM_W+RB-1:0] w_psr;

    logic             w_div_start, w_div_busy;
    logic [DVD_W-1:0] w_dvd, w_q;
    logic [DVS_W-1:0] w_dvs;
    logic [PRED_W-1:0] w_pred_sat;

    logic [SQ_IN_W-1:0] r_rad;
    logic [SIM_W-1:0]   r_root;
    logic [SIM_W:0]     r_srem;
    logic [4:0]         r_scnt;
    logic               r_sbusy;
    logic [SIM_W+2:0]   w_st, w_trial;

    logic              r_best_v;
    logic [PRED_W-1:0] r_best_pred;
    logic [MB-1:0]     r_best_movie, r_best_idx;
    logic [2**MB-1:0]  r_used;

    logic              r_ovld, r_ofound, r_olast;
    logic [4:0]        r_omovie;
    logic [PRED_W-1:0] r_opred;
    logic              w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_we) begin
            r_store[{i_st_wuser, i_st_wmovie}] <= i_st_wdata;
        end
        r_ra <= r_store[{i_tgt, i_movie}];
        r_rb <= r_store[{i_user, i_movie}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cache_we) begin
            r_cache[i_user] <= i_cmd.cache_zero ? '0 : r_root;
        end
        r_sim_q <= r_cache[i_user];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.list_we) begin
            r_list[i_list_waddr] <= {i_movie, i_cmd.pred_zero ? '0 : w_pred_sat};
        end
        r_lq <= r_list[i_list_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sim_v  <= 1'b0;
            r_pred_v <= 1'b0;
            r_self_d <= 1'b0;
            r_sel_v  <= 1'b0;
            r_j_d    <= '0;
        end else begin
            r_sim_v  <= i_cmd.sim_acc;
            r_pred_v <= i_cmd.pred_acc;
            r_self_d <= i_cmd.self_u;
            r_sel_v  <= i_cmd.sel_acc;
            r_j_d    <= i_list_raddr;
        end
    end

    assign w_pxy = (2*RB)'(r_ra) * (2*RB)'(r_rb);
    assign w_pxx = (2*RB)'(r_ra) * (2*RB)'(r_ra);
    assign w_pyy = (2*RB)'(r_rb) * (2*RB)'(r_rb);
    assign w_psr = (SIM_W+RB)'(r_sim_q) * (SIM_W+RB)'(r_rb);

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_dot <= '0;
            r_n1  <= '0;
            r_n2  <= '0;
            r_ws  <= '0;
            r_ss  <= '0;
        end else begin
            // co-rated movies only
            if (r_sim_v && r_ra != '0 && r_rb != '0) begin
                r_dot <= r_dot + ACC_W'(w_pxy);
                r_n1  <= r_n1 + ACC_W'(w_pxx);
                r_n2  <= r_n2 + ACC_W'(w_pyy);
            end
            // other users with a rating of this movie
            if (r_pred_v && !r_self_d && r_rb != '0) begin
                r_ws <= r_ws + WS_W'(w_psr);
                r_ss <= r_ss + SS_W'(r_sim_q);
            end
        end
        if (i_cmd.sim_mul) begin
            r_num <= P_W'(r_dot) * P_W'(r_dot);
            r_p   <= P_W'(r_n1) * P_W'(r_n2);
        end
    end

    assign w_div_start = i_cmd.div_sim_start | i_cmd.div_pred_start;
    assign w_dvd = i_cmd.div_sim_start ? DVD_W'({r_num, 32'd0}) : DVD_W'({r_ws, 12'd0});
    assign w_dvs = i_cmd.div_sim_start ? DVS_W'(r_p) : DVS_W'(r_ss);

    ccf_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_dvd  (w_dvd),
        .i_dvs  (w_dvs),
        .o_busy (w_div_busy),
        .o_q    (w_q)
    );

    assign w_pred_sat = (|w_q[DVD_W-1:PRED_W]) ? {PRED_W{1'b1}} : w_q[PRED_W-1:0];

    // square root, two radicand bits per step
    assign w_st    = {r_srem, r_rad[SQ_IN_W-1:SQ_IN_W-2]};
    assign w_trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
            r_scnt  <= '0;
        end else if (i_cmd.sqrt_start) begin
            r_sbusy <= 1'b1;
            r_scnt  <= 5'(SQ_STEPS);
        end else if (r_sbusy) begin
            r_scnt <= r_scnt - 5'd1;
            if (r_scnt == 5'd1) begin
                r_sbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_rad  <= w_q[SQ_IN_W-1:0];
            r_root <= '0;
            r_srem <= '0;
        end else if (r_sbusy) begin
            r_rad <= {r_rad[SQ_IN_W-3:0], 2'b00};
            if (w_st >= w_trial) begin
                r_srem <= (SIM_W+1)'(w_st - w_trial);
                r_root <= {r_root[SIM_W-2:0], 1'b1};
            end else begin
                r_srem <= w_st[SIM_W:0];
                r_root <= {r_root[SIM_W-2:0], 1'b0};
            end
        end
    end

    // selection scan, list is in ascending movie order so ties keep the first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_v <= 1'b0;
            r_used   <= '0;
        end else begin
            if (i_cmd.q_start) begin
                r_used <= '0;
            end else if (i_cmd.out_load_item) begin
                r_used[r_best_idx] <= 1'b1;
            end
            if (i_cmd.sel_clr) begin
                r_best_v <= 1'b0;
            end else if (r_sel_v && !r_used[r_j_d] &&
                         (!r_best_v || r_lq[PRED_W-1:0] > r_best_pred)) begin
                r_best_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_cmd.sel_clr && r_sel_v && !r_used[r_j_d] &&
            (!r_best_v || r_lq[PRED_W-1:0] > r_best_pred)) begin
            r_best_pred  <= r_lq[PRED_W-1:0];
            r_best_movie <= r_lq[LW-1:PRED_W];
            r_best_idx   <= r_j_d;
        end
    end

    // output register
    assign w_out_free = !r_ovld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load_item || i_cmd.out_load_none) begin
            r_ovld <= 1'b1;
        end else if (i_m_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_item) begin
            r_omovie <= 5'(r_best_movie);
            r_opred  <= r_best_pred;
            r_ofound <= 1'b1;
            r_olast  <= i_cmd.out_last;
        end else if (i_cmd.out_load_none) begin
            r_omovie <= '0;
            r_opred  <= '0;
            r_ofound <= 1'b0;
            r_olast  <= 1'b1;
        end
    end

    assign o_sts.p_zero    = (r_p == '0);
    assign o_sts.ss_zero   = (r_ss == '0);
    assign o_sts.div_done  = !w_div_busy;
    assign o_sts.sqrt_done = !r_sbusy;
    assign o_sts.tgt_rated = (r_ra != '0);
    assign o_sts.out_free  = w_out_free;

    assign o_m_valid  = r_ovld;
    assign o_movie_id = r_omovie;
    assign o_pred     = r_opred;
    assign o_found    = r_ofound;
    assign o_last     = r_olast;
endmodule

// ===== sv/cosine_cf_top_n_recommender.sv =====
// top level of the cosine similarity top-n movie recommender
//
// input stream: each beat is a load (tuser 0) that writes one rating into the
// user-by-movie store, or a query (tuser 1) for the user in user_index.
// a load emits nothing; loads stream at one beat a cycle.
// a query walks the store twice: for every active user one pass over the active
// movies and a product stage, then, unless the product is zero or the user is the
// target, a bit-serial divide and a 17-step square root; then for every unrated
// movie one pass over the users and a divide unless the similarity sum is zero;
// a rated movie is skipped.
// selection scans the list of the cnt unrated movies once for every emitted beat.
// the similarity and prediction walks share one divider; the similarity walk reads one movie per cycle.
// output stream: up to top_n beats, best prediction first, tlast on the final
// one; a query with nothing to recommend emits a single beat with tuser 0.
// a finished beat sits in an output register, so a stalled receiver only holds
// the selection; input is taken again once the last beat is registered.
// reset: a clearing pass writes zero to every one of the 2**(clog2(MAX_USERS) +
// clog2(MAX_MOVIES)) store entries (2048 by default), one per cycle; the input
// is not ready during it, while configuration writes are taken at any time.
`include "assert_macros.svh"

module cosine_cf_top_n_recommender #(
    parameter int MAX_USERS   = 64,
    parameter int MAX_MOVIES  = 32,
    parameter int RATING_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // user_index[5:0], movie_index[10:6], rating[14:11]
    input  logic [0:0]  i_s_tuser,   // action[0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // movie_id[4:0], predicted_rating[20:5]
    output logic [0:0]  o_m_tuser,   // found[0]
    output logic        o_m_tlast,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import ccf_pkg::*;

    localparam int UB = $clog2(MAX_USERS);
    localparam int MB = MAX_MOVIES > 1 ? $clog2(MAX_MOVIES) : 1;

    // configuration registers
    logic [5:0] r_top_n;
    logic [6:0] r_users;
    logic [5:0] r_movies;

    t_cmd w_cmd;
    t_sts w_sts;

    logic [UB-1:0]          w_user, w_tgt, w_st_wuser;
    logic [MB-1:0]          w_movie, w_list_raddr, w_list_waddr, w_st_wmovie;
    logic [RATING_BITS-1:0] w_st_wdata;
    logic [4:0]             w_movie_id;
    logic [15:0]            w_pred;
    logic                   w_found, w_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_n  <= 6'd3;
            r_users  <= 7'd64;
            r_movies <= 6'd32;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TOP_N:  r_top_n  <= i_cfg_data[5:0];
                CFG_USERS:  r_users  <= i_cfg_data;
                CFG_MOVIES: r_movies <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // sequencer
    ccf_ctrl #(
        .MAX_USERS  (MAX_USERS),
        .MAX_MOVIES (MAX_MOVIES),
        .RATING_BITS(RATING_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_action     (i_s_tuser[0]),
        .i_user_index (i_s_tdata[5:0]),
        .i_movie_index(i_s_tdata[10:6]),
        .i_rating     (i_s_tdata[14:11]),
        .i_top_n      (r_top_n),
        .i_users      (r_users),
        .i_movies     (r_movies),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_user       (w_user),
        .o_tgt        (w_tgt),
        .o_movie      (w_movie),
        .o_list_raddr (w_list_raddr),
        .o_list_waddr (w_list_waddr),
        .o_st_wuser   (w_st_wuser),
        .o_st_wmovie  (w_st_wmovie),
        .o_st_wdata   (w_st_wdata)
    );

    // store, arithmetic and output register
    ccf_dp #(
        .MAX_USERS  (MAX_USERS),
        .MAX_MOVIES (MAX_MOVIES),
        .RATING_BITS(RATING_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_user      (w_user),
        .i_tgt       (w_tgt),
        .i_movie     (w_movie),
        .i_list_raddr(w_list_raddr),
        .i_list_waddr(w_list_waddr),
        .i_st_wuser  (w_st_wuser),
        .i_st_wmovie (w_st_wmovie),
        .i_st_wdata  (w_st_wdata),
        .i_m_tready  (i_m_tready),
        .o_m_valid   (o_m_tvalid),
        .o_movie_id  (w_movie_id),
        .o_pred      (w_pred),
        .o_found     (w_found),
        .o_last      (w_last)
    );

    assign o_m_tdata = {3'b000, w_pred, w_movie_id};
    assign o_m_tuser = w_found;
    assign o_m_tlast = w_last;

    // a result is only registered into a free output slot
    `AST_IMP(a_out_slot, i_clk, i_rst_n, w_cmd.out_load_item || w_cmd.out_load_none, w_sts.out_free)
    // the divider is never started with a zero divisor
    `AST_IMP(a_div_nonzero, i_clk, i_rst_n, w_cmd.div_sim_start || w_cmd.div_pred_start, !(w_cmd.div_sim_start && w_sts.p_zero) && !(w_cmd.div_pred_start && w_sts.ss_zero))
    // a registered result shows up as a valid beat
    `AST_NXT(a_out_shown, i_clk, i_rst_n, w_cmd.out_load_item || w_cmd.out_load_none, o_m_tvalid)
    // a started divide reports busy on the next cycle
    `AST_NXT(a_div_busy, i_clk, i_rst_n, w_cmd.div_sim_start || w_cmd.div_pred_start, !w_sts.div_done)

endmodule
